>>> hw/rtl/sorted_priority_queue_core_macros.svh
// Assertion macros used by the checker file of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define SPQ_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SPQ_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Field widths fixed by the request and result words.
    localparam int DataW = 32;
    localparam int PrioW = 8;
    localparam int FillW = 5;

    // Request codes.
    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_POP_HIGH = 2'd1;
    localparam logic [1:0] REQ_POP_LOW  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One held entry.
    typedef struct packed {
        logic signed [DataW-1:0] data;
        logic [PrioW-1:0]        prio;
    } t_entry;

    // Operation broadcast to every cell in a cycle.
    typedef struct packed {
        logic ins;
        logic pop_front;
        logic pop_back;
    } t_cell_op;

    // What one cell shows its neighbours.
    typedef struct packed {
        logic   valid;
        logic   keep;
        t_entry entry;
    } t_link;

endpackage

`default_nettype wire

>>> hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cell_op i_op,
    input  wire t_entry   i_new,
    input  wire t_link    i_left,
    input  wire t_link    i_right,
    output t_link         o_self
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   w_keep;

    // An entry stays put on insert when its priority is at least the new one.
    assign w_keep = r_valid && (r_entry.prio >= i_new.prio);

    // Next contents: hold, take the new word, or shift in from a neighbour.
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_op.ins) begin
            if (!w_keep) begin
                if (i_left.keep) begin
                    n_valid = 1'b1;
                    n_entry = i_new;
                end else begin
                    n_valid = i_left.valid;
                    n_entry = i_left.entry;
                end
            end
        end else if (i_op.pop_front) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end else if (i_op.pop_back) begin
            // Only the last occupied cell lets go of its word.
            n_valid = r_valid && i_right.valid;
        end
    end

    // Occupancy flag is control state; the word itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_self.valid = r_valid;
    assign o_self.keep  = w_keep;
    assign o_self.entry = r_entry;

endmodule

`default_nettype wire

>>> hw/rtl/sorted_priority_queue_core.sv
// Sorted priority queue held in a row of DEPTH shift cells, front entry in cell 0.
// Latency: the result word is strobed in the cycle after the request is accepted.
// Throughput: one request per cycle for any request type; busy is never raised.
// All cells compare against the new priority at once and shift by one place together.
// Reset (synchronous, active low) empties the queue and clears the strobe.
// The receiver cannot stall: each result word is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_core import spq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              i_req_type,
    input  wire logic signed [DataW-1:0] i_in_data,
    input  wire logic [PrioW-1:0]        i_in_priority,
    output logic                         o_strobe,
    output logic [1:0]                   o_status,
    output logic signed [DataW-1:0]      o_out_data,
    output logic [PrioW-1:0]             o_out_priority,
    output logic [FillW-1:0]             o_fill_count
);

    localparam int CntW = $clog2(DEPTH + 1);

    t_link          w_links [DEPTH];
    t_link          w_left  [DEPTH];
    t_link          w_right [DEPTH];
    t_cell_op       w_op;
    t_entry         w_new;
    t_entry         w_tail;
    logic           w_accept;
    logic           w_full;
    logic           w_empty;

    logic [CntW-1:0]      r_count;
    logic [CntW-1:0]      n_count;
    logic [CntW+FillW-1:0] w_cnt_ext;
    logic                 r_strobe;
    logic [1:0]           r_status;
    logic [1:0]           n_status;
    t_entry               r_out;
    t_entry               n_out;
    logic [FillW-1:0]     r_fill;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = w_links[DEPTH-1].valid;
    assign w_empty  = !w_links[0].valid;

    assign w_new.data = i_in_data;
    assign w_new.prio = i_in_priority;

    // Decode the request into the operation every cell sees.
    always_comb begin
        w_op = '0;
        if (w_accept) begin
            unique case (i_req_type)
                REQ_INSERT:   w_op.ins       = !w_full;
                REQ_POP_HIGH: w_op.pop_front = !w_empty;
                REQ_POP_LOW:  w_op.pop_back  = !w_empty;
                default:      w_op           = '0;
            endcase
        end
    end

    // Neighbour wiring: the head sees a keeping, empty left side; the tail an empty right.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_left[gi] = '{valid: 1'b0, keep: 1'b1, entry: '0};
            end else begin : g_mid_l
                assign w_left[gi] = w_links[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign w_right[gi] = '0;
            end else begin : g_mid_r
                assign w_right[gi] = w_links[gi+1];
            end

            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_op),
                .i_new   (w_new),
                .i_left  (w_left[gi]),
                .i_right (w_right[gi]),
                .o_self  (w_links[gi])
            );
        end
    endgenerate

    // Pick the last occupied cell; exactly one cell matches when the queue is not empty.
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_links[i].valid && !w_right[i].valid) begin
                w_tail = w_tail | w_links[i].entry;
            end
        end
    end

    // Result word and new fill count.
    always_comb begin
        n_status = ST_OK;
        n_out    = '0;
        n_count  = r_count;
        unique case (i_req_type)
            REQ_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP_HIGH: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out   = w_links[0].entry;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_POP_LOW: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out   = w_tail;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign w_cnt_ext = {{FillW{1'b0}}, n_count};

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_out    <= n_out;
            r_fill   <= w_cnt_ext[FillW-1:0];
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_data     = r_out.data;
    assign o_out_priority = r_out.prio;
    assign o_fill_count   = r_fill;

endmodule

`default_nettype wire

>>> hw/rtl/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_core_macros.svh"

module spq_checker import spq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic [1:0]              i_req_type,
    input wire logic signed [DataW-1:0] i_in_data,
    input wire logic [PrioW-1:0]        i_in_priority,
    input wire logic                    o_strobe,
    input wire logic [1:0]              o_status,
    input wire logic signed [DataW-1:0] o_out_data,
    input wire logic [PrioW-1:0]        o_out_priority,
    input wire logic [FillW-1:0]        o_fill_count
);

    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [CntW+FillW-1:0] DepthExt = (CntW + FillW)'(DEPTH);

    // Every accepted word yields exactly one result word in the next cycle.
    `SPQ_ASSERT_ALL(a_strobe_follows, (i_rst_n && start && !busy) |=> o_strobe, "missing result word")
    `SPQ_ASSERT_ALL(a_no_spurious, (!i_rst_n || !start || busy) |=> !o_strobe, "result word without request")

    // An empty report carries no entry and a zero fill count.
    `SPQ_ASSERT_RUN(a_empty_word, (o_strobe && o_status == ST_EMPTY) |-> (o_out_data == '0 && o_out_priority == '0 && o_fill_count == '0), "bad empty word")

    // A full report carries no entry and shows the queue at capacity.
    `SPQ_ASSERT_RUN(a_full_word, (o_strobe && o_status == ST_FULL) |-> (o_out_data == '0 && o_out_priority == '0 && o_fill_count == DepthExt[FillW-1:0]), "bad full word")

endmodule

bind sorted_priority_queue_core spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

`default_nettype wire
